/* hw/rtl/rhi_pkg.sv */
// ----------------------------------------------------------------------------
// rhi_pkg
// Shared types and constants for the ray / hyperboloid intersection pipeline.
// ----------------------------------------------------------------------------
package rhi_pkg;

   localparam int CW = 32;

   // hit status codes
   localparam logic [1:0] ST_HIT   = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_DEGEN = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_CONE_TAN_SQ = 2'd0;
   localparam logic [1:0] CSR_OPEN_OFFSET = 2'd1;

   // coefficient saturation bound, 2^62 - 1 raw
   localparam logic signed [63:0] LIM62 = 64'sh3FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [CW-1:0] eye_x;
      logic signed [CW-1:0] eye_y;
      logic signed [CW-1:0] eye_z;
      logic signed [CW-1:0] dir_x;
      logic signed [CW-1:0] dir_y;
      logic signed [CW-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] near_root;
      logic signed [CW-1:0] far_root;
      logic [1:0]           hit_status;
   } rsp_type;

   typedef struct packed {
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] c;
   } coef_type;

   // travels alongside the discriminant / root
   typedef struct packed {
      logic [1:0]         status;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } side_type;

endpackage

/* hw/rtl/rhi_coef.sv */
// ----------------------------------------------------------------------------
// rhi_coef
// Five-stage pipeline forming the quadratic coefficients A, B, C.
// ----------------------------------------------------------------------------
module rhi_coef #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rhi_pkg::req_type    in_req,
   input  logic [31:0]         cone_tan_sq,
   input  logic signed [31:0]  open_offset,
   output logic                out_valid,
   output rhi_pkg::coef_type   out_coef
);
   import rhi_pkg::*;

   localparam int WW = 98;

   logic [4:0] vld_ff;

   logic signed [63:0] p_xx_ff, p_yy_ff, p_zz_ff, p_xe_ff, p_ye_ff, p_ze_ff;
   logic signed [63:0] e_xx_ff, e_yy_ff, e_zz_ff;

   logic [63:0]        sa_ff, sc_ff;
   logic signed [64:0] sb_ff;
   logic [63:0]        za_hi_ff, za_lo_ff, zc_hi_ff, zc_lo_ff, zb_lo_ff;
   logic signed [64:0] zb_hi_ff;

   logic [63:0]        sa3_ff, sc3_ff;
   logic signed [64:0] sb3_ff;
   logic [95:0]        tz_a_ff, tz_c_ff;
   logic signed [97:0] tz_b_ff;

   logic signed [WW-1:0] wa_ff, wb_ff, wc_ff;
   coef_type             coef_ff;

   function automatic logic signed [63:0] sat62(input logic signed [WW-1:0] w);
      logic signed [WW-1:0] x;
      x = w >>> (2*FRAC_BITS);
      if (x > WW'(LIM62)) sat62 = LIM62;
      else if (x < -WW'(LIM62)) sat62 = -LIM62;
      else sat62 = x[63:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: 32x32 products
         p_xx_ff <= in_req.dir_x * in_req.dir_x;
         p_yy_ff <= in_req.dir_y * in_req.dir_y;
         p_zz_ff <= in_req.dir_z * in_req.dir_z;
         p_xe_ff <= in_req.dir_x * in_req.eye_x;
         p_ye_ff <= in_req.dir_y * in_req.eye_y;
         p_ze_ff <= in_req.dir_z * in_req.eye_z;
         e_xx_ff <= in_req.eye_x * in_req.eye_x;
         e_yy_ff <= in_req.eye_y * in_req.eye_y;
         e_zz_ff <= in_req.eye_z * in_req.eye_z;
         // stage 2: sums and halves of the products with t
         sa_ff    <= $unsigned(p_xx_ff) + $unsigned(p_yy_ff);
         sb_ff    <= 65'(p_xe_ff) + 65'(p_ye_ff);
         sc_ff    <= $unsigned(e_xx_ff) + $unsigned(e_yy_ff);
         za_hi_ff <= p_zz_ff[63:32] * cone_tan_sq;
         za_lo_ff <= p_zz_ff[31:0] * cone_tan_sq;
         zb_hi_ff <= $signed(p_ze_ff[63:32]) * $signed({1'b0, cone_tan_sq});
         zb_lo_ff <= p_ze_ff[31:0] * cone_tan_sq;
         zc_hi_ff <= e_zz_ff[63:32] * cone_tan_sq;
         zc_lo_ff <= e_zz_ff[31:0] * cone_tan_sq;
         // stage 3: merge halves
         sa3_ff  <= sa_ff;
         sb3_ff  <= sb_ff;
         sc3_ff  <= sc_ff;
         tz_a_ff <= {za_hi_ff, 32'd0} + 96'(za_lo_ff);
         tz_c_ff <= {zc_hi_ff, 32'd0} + 96'(zc_lo_ff);
         tz_b_ff <= 98'($signed({zb_hi_ff, 32'd0})) + $signed(98'(zb_lo_ff));
         // stage 4: exact coefficients at scale 2^(3F)
         wa_ff <= $signed(WW'(sa3_ff) << FRAC_BITS) - $signed(WW'(tz_a_ff));
         wb_ff <= (WW'(sb3_ff) <<< (FRAC_BITS + 1)) - (WW'(tz_b_ff) <<< 1);
         wc_ff <= $signed(WW'(sc3_ff) << FRAC_BITS) - $signed(WW'(tz_c_ff))
                  + (WW'(open_offset) <<< (2*FRAC_BITS));
         // stage 5: floor to Q(F) and clamp
         coef_ff.a <= sat62(wa_ff);
         coef_ff.b <= sat62(wb_ff);
         coef_ff.c <= sat62(wc_ff);
      end
   end

   assign out_valid = vld_ff[4];
   assign out_coef  = coef_ff;

endmodule

/* hw/rtl/rhi_disc.sv */
// ----------------------------------------------------------------------------
// rhi_disc
// Four-stage pipeline for D = B*B - 4*A*C and the hit status.
// ----------------------------------------------------------------------------
module rhi_disc (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rhi_pkg::coef_type   in_coef,
   output logic                out_valid,
   output logic [127:0]        out_disc,
   output rhi_pkg::side_type   out_side
);
   import rhi_pkg::*;

   logic [3:0] vld_ff;

   logic signed [63:0] abs_a, abs_b, abs_c;
   logic [61:0]        ma_ff, mb_ff, mc_ff;
   logic               sac_ff, azero_ff;
   logic signed [63:0] a1_ff, b1_ff;

   logic [61:0] bb_hh_ff, bb_hl_ff, bb_ll_ff;
   logic [61:0] ac_hh_ff, ac_hl_ff, ac_lh_ff, ac_ll_ff;
   logic        sac2_ff, azero2_ff;
   logic signed [63:0] a2_ff, b2_ff;

   logic [123:0] bb_ff, ac_ff;
   logic         sac3_ff, azero3_ff;
   logic signed [63:0] a3_ff, b3_ff;

   logic signed [127:0] disc_in;
   logic [127:0]        disc_ff;
   side_type            side_in, side_ff;

   always_comb begin
      abs_a = in_coef.a[63] ? -in_coef.a : in_coef.a;
      abs_b = in_coef.b[63] ? -in_coef.b : in_coef.b;
      abs_c = in_coef.c[63] ? -in_coef.c : in_coef.c;
   end

   always_comb begin
      if (sac3_ff) disc_in = $signed({4'b0, bb_ff}) + $signed({2'b0, ac_ff, 2'b0});
      else disc_in = $signed({4'b0, bb_ff}) - $signed({2'b0, ac_ff, 2'b0});
      side_in.a = a3_ff;
      side_in.b = b3_ff;
      if (azero3_ff) side_in.status = ST_DEGEN;
      else if (disc_in[127]) side_in.status = ST_MISS;
      else side_in.status = ST_HIT;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ma_ff    <= abs_a[61:0];
         mb_ff    <= abs_b[61:0];
         mc_ff    <= abs_c[61:0];
         sac_ff   <= in_coef.a[63] ^ in_coef.c[63];
         azero_ff <= (in_coef.a == '0);
         a1_ff    <= in_coef.a;
         b1_ff    <= in_coef.b;
         // 31-bit digit partial products
         bb_hh_ff  <= mb_ff[61:31] * mb_ff[61:31];
         bb_hl_ff  <= mb_ff[61:31] * mb_ff[30:0];
         bb_ll_ff  <= mb_ff[30:0] * mb_ff[30:0];
         ac_hh_ff  <= ma_ff[61:31] * mc_ff[61:31];
         ac_hl_ff  <= ma_ff[61:31] * mc_ff[30:0];
         ac_lh_ff  <= ma_ff[30:0] * mc_ff[61:31];
         ac_ll_ff  <= ma_ff[30:0] * mc_ff[30:0];
         sac2_ff   <= sac_ff;
         azero2_ff <= azero_ff;
         a2_ff     <= a1_ff;
         b2_ff     <= b1_ff;
         // cross term of B*B appears twice: 2 * hl * 2^31
         bb_ff     <= {bb_hh_ff, 62'd0} + (124'(bb_hl_ff) << 32) + 124'(bb_ll_ff);
         ac_ff     <= {ac_hh_ff, 62'd0} + ((124'(ac_hl_ff) + 124'(ac_lh_ff)) << 31)
                      + 124'(ac_ll_ff);
         sac3_ff   <= sac2_ff;
         azero3_ff <= azero2_ff;
         a3_ff     <= a2_ff;
         b3_ff     <= b2_ff;
         disc_ff   <= disc_in;
         side_ff   <= side_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_disc  = disc_ff;
   assign out_side  = side_ff;

endmodule

/* hw/rtl/rhi_isqrt.sv */
// ----------------------------------------------------------------------------
// rhi_isqrt
// Integer square root of a 128-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module rhi_isqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [127:0]        in_rad,
   input  rhi_pkg::side_type   in_side,
   output logic                out_valid,
   output logic [63:0]         out_root,
   output rhi_pkg::side_type   out_side
);
   import rhi_pkg::*;

   localparam int SQ_STEPS = 64;

   logic [SQ_STEPS-1:0] vld_ff;
   logic [127:0]        rad_ff  [SQ_STEPS];
   logic [65:0]         rem_ff  [SQ_STEPS];
   logic [63:0]         root_ff [SQ_STEPS];
   side_type            side_ff [SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[SQ_STEPS-2:0], in_valid};
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic [65:0]  rem_prev;
      logic [63:0]  root_prev;
      logic [127:0] rad_prev;
      side_type     side_prev;
      logic [67:0]  acc, trial;
      logic [65:0]  rem_in;
      logic [63:0]  root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         acc   = {rem_prev, rad_prev[127:126]};
         trial = {2'b00, root_prev, 2'b01};
         if (acc >= trial) begin
            rem_in  = 66'(acc - trial);
            root_in = {root_prev[62:0], 1'b1};
         end else begin
            rem_in  = acc[65:0];
            root_in = {root_prev[62:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_prev << 2;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

/* hw/rtl/rhi_div.sv */
// ----------------------------------------------------------------------------
// rhi_div
// Root quotients: three setup stages, two 32-step restoring dividers in
// lockstep, then saturation and the result register.
// ----------------------------------------------------------------------------
module rhi_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [63:0]         in_root,
   input  rhi_pkg::side_type   in_side,
   output logic                out_valid,
   output rhi_pkg::rsp_type    out_rsp
);
   import rhi_pkg::*;

   localparam int QS = 32;
   localparam int NW = 65 + FRAC_BITS;

   // setup stage 1
   logic signed [63:0] nb, abs_a;
   logic               p1_vld_ff;
   logic signed [65:0] num1_ff [2];
   logic [62:0]        ma1_ff;
   logic               sa1_ff;
   logic [1:0]         st1_ff;

   // setup stage 2
   logic               p2_vld_ff;
   logic [64:0]        mag2_ff [2];
   logic               neg2_ff [2];
   logic [63:0]        d2_ff;
   logic [1:0]         st2_ff;

   // divider stages, entry 0 is loaded by setup stage 3
   logic [QS:0]  vld_ff;
   logic [63:0]  rem_ff [2][QS+1];
   logic [31:0]  lo_ff  [2][QS+1];
   logic [31:0]  q_ff   [2][QS+1];
   logic         neg_ff [2][QS+1];
   logic         ovf_ff [2][QS+1];
   logic [63:0]  d_ff   [QS+1];
   logic [1:0]   st_ff  [QS+1];

   logic    out_vld_ff;
   rsp_type rsp_in, rsp_ff;

   function automatic logic [31:0] sat_q(input logic [31:0] q, input logic neg,
                                         input logic ovf);
      if (neg) begin
         if (ovf || q > 32'h8000_0000) sat_q = 32'h8000_0000;
         else sat_q = -q;
      end else begin
         if (ovf || q > 32'h7FFF_FFFF) sat_q = 32'h7FFF_FFFF;
         else sat_q = q;
      end
   endfunction

   always_comb begin
      nb    = -in_side.b;
      abs_a = in_side.a[63] ? -in_side.a : in_side.a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff  <= in_valid;
         p2_vld_ff  <= p1_vld_ff;
         vld_ff     <= {vld_ff[QS-1:0], p2_vld_ff};
         out_vld_ff <= vld_ff[QS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num1_ff[0] <= 66'(nb) - $signed({2'b00, in_root});
         num1_ff[1] <= 66'(nb) + $signed({2'b00, in_root});
         ma1_ff     <= abs_a[62:0];
         sa1_ff     <= in_side.a[63];
         st1_ff     <= in_side.status;
         d2_ff      <= {ma1_ff, 1'b0};
         st2_ff     <= st1_ff;
         d_ff[0]    <= d2_ff;
         st_ff[0]   <= st2_ff;
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [65:0] abs_num;
      logic [NW-1:0]      numer;

      always_comb begin
         abs_num = num1_ff[l][65] ? -num1_ff[l] : num1_ff[l];
         numer   = {mag2_ff[l], FRAC_BITS'(0)};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            mag2_ff[l]   <= abs_num[64:0];
            neg2_ff[l]   <= num1_ff[l][65] ^ sa1_ff;
            // upper part already at or above the divisor: quotient needs > 32 bits
            rem_ff[l][0] <= 64'(numer[NW-1:32]);
            ovf_ff[l][0] <= 64'(numer[NW-1:32]) >= d2_ff;
            lo_ff[l][0]  <= numer[31:0];
            q_ff[l][0]   <= '0;
            neg_ff[l][0] <= neg2_ff[l];
         end
      end

      for (genvar j = 1; j <= QS; j++) begin : g_step
         logic [64:0] r2;
         logic [63:0] rem_in;
         logic [31:0] q_in;

         always_comb begin
            r2 = {rem_ff[l][j-1], lo_ff[l][j-1][31]};
            if (r2 >= 65'(d_ff[j-1])) begin
               rem_in = 64'(r2 - 65'(d_ff[j-1]));
               q_in   = {q_ff[l][j-1][30:0], 1'b1};
            end else begin
               rem_in = r2[63:0];
               q_in   = {q_ff[l][j-1][30:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[l][j] <= rem_in;
               q_ff[l][j]   <= q_in;
               lo_ff[l][j]  <= lo_ff[l][j-1] << 1;
               neg_ff[l][j] <= neg_ff[l][j-1];
               ovf_ff[l][j] <= ovf_ff[l][j-1];
            end
         end
      end
   end

   for (genvar j = 1; j <= QS; j++) begin : g_common
      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[j]  <= d_ff[j-1];
            st_ff[j] <= st_ff[j-1];
         end
      end
   end

   always_comb begin
      rsp_in.hit_status = st_ff[QS];
      if (st_ff[QS] == ST_HIT) begin
         rsp_in.near_root = sat_q(q_ff[0][QS], neg_ff[0][QS], ovf_ff[0][QS]);
         rsp_in.far_root  = sat_q(q_ff[1][QS], neg_ff[1][QS], ovf_ff[1][QS]);
      end else begin
         // -1.0
         rsp_in.near_root = ~((32'd1 << FRAC_BITS) - 32'd1);
         rsp_in.far_root  = ~((32'd1 << FRAC_BITS) - 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign out_valid = out_vld_ff;
   assign out_rsp   = rsp_ff;

endmodule

/* hw/rtl/ray_hyperboloid_intersect_top.sv */
// ----------------------------------------------------------------------------
// ray_hyperboloid_intersect_top
// Intersects Q16.16 rays with a z-axis hyperboloid x^2+y^2-t*z^2+open=0.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle while rsp_stall does not
// hold a waiting result, and each result passes 5 coefficient stages, 4
// discriminant stages, 64 square root stages, 3 divider setup stages, 32
// divider stages and the result register. The 64-step square root and the
// 32-step quotient make up most of that depth. One global enable moves the
// whole pipeline; a stalled result holds every stage, so req_stall follows
// rsp_stall while a result is waiting. Write cone_tan_sq and open_offset only
// while no request is in flight. hit_status: 0 two roots, 1 miss, 2
// degenerate (a is zero); both roots read -1.0 unless two roots were found.
// ----------------------------------------------------------------------------
module ray_hyperboloid_intersect_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rhi_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rhi_pkg::rsp_type  rsp_data,
   input  logic              csr_wen,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import rhi_pkg::*;

   logic        adv;
   logic [31:0] cone_tan_sq_ff;
   logic [31:0] open_offset_ff;

   logic         coef_valid, disc_valid, root_valid;
   coef_type     coef;
   logic [127:0] disc;
   side_type     disc_side, root_side;
   logic [63:0]  root;

   always_ff @(posedge clock) begin
      if (reset) begin
         cone_tan_sq_ff <= 32'h0001_0000;
         open_offset_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_CONE_TAN_SQ: cone_tan_sq_ff <= csr_wdata;
            CSR_OPEN_OFFSET: open_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   rhi_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_req      (req_data),
      .cone_tan_sq (cone_tan_sq_ff),
      .open_offset ($signed(open_offset_ff)),
      .out_valid   (coef_valid),
      .out_coef    (coef)
   );

   rhi_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (coef_valid),
      .in_coef   (coef),
      .out_valid (disc_valid),
      .out_disc  (disc),
      .out_side  (disc_side)
   );

   rhi_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (disc_valid),
      .in_rad    (disc),
      .in_side   (disc_side),
      .out_valid (root_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   rhi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (root_valid),
      .in_root   (root),
      .in_side   (root_side),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ray_hyperboloid_intersect_top: requests are driven
// from a queue, each accepted ray is solved in exact wide arithmetic, and
// every result is compared field by field in arrival order, over several
// register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import rhi_pkg::*;

   localparam int FRAC = 16;
   localparam int PIPE_DEPTH = 109;
   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   req_type ray_q[$];
   rsp_type hit_q[$];
   logic [31:0] tan_sq_reg;
   logic [31:0] open_reg;
   int idle_pct = 0;
   int stall_pct = 0;
   int cycles = 0;
   bit failed = 0;

   ray_hyperboloid_intersect_top #(.FRAC_BITS(FRAC)) dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wen, .csr_index, .csr_wdata
   );

   always #1 clock = ~clock;

   function automatic logic signed [127:0] sat62(input logic signed [127:0] v);
      logic signed [127:0] lim;
      lim = 128'(LIM62);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic [31:0] quot32(input logic signed [127:0] num,
                                          input logic signed [127:0] den);
      logic signed [127:0] q;
      q = num / den;
      if (q > 128'sd2147483647) return 32'h7FFF_FFFF;
      if (q < -128'sd2147483648) return 32'h8000_0000;
      return q[31:0];
   endfunction

   // roots of a*k^2 + b*k + c for one ray against the current surface
   function automatic rsp_type solve_ray(input req_type r);
      logic signed [127:0] ex, ey, ez, dx, dy, dz, t, op;
      logic signed [127:0] wa, wb, wc, qa, qb, qc, disc, nb, sq;
      logic [127:0] disc_u;
      logic [63:0] root, cand;
      rsp_type o;
      ex = 128'(r.eye_x); ey = 128'(r.eye_y); ez = 128'(r.eye_z);
      dx = 128'(r.dir_x); dy = 128'(r.dir_y); dz = 128'(r.dir_z);
      t = $signed({96'd0, tan_sq_reg});
      op = 128'($signed(open_reg));
      wa = ((dx * dx + dy * dy) <<< FRAC) - dz * dz * t;
      wb = ((dx * ex + dy * ey) <<< (FRAC + 1)) - ((dz * ez * t) <<< 1);
      wc = ((ex * ex + ey * ey) <<< FRAC) - ez * ez * t + (op <<< (2 * FRAC));
      qa = sat62(wa >>> (2 * FRAC));
      qb = sat62(wb >>> (2 * FRAC));
      qc = sat62(wc >>> (2 * FRAC));
      o.near_root = -(32'sd1 <<< FRAC);
      o.far_root = -(32'sd1 <<< FRAC);
      if (qa == 0) begin
         o.hit_status = ST_DEGEN;
         return o;
      end
      disc = qb * qb - ((qa * qc) <<< 2);
      if (disc < 0) begin
         o.hit_status = ST_MISS;
         return o;
      end
      disc_u = disc;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         cand = root | (64'd1 << i);
         if ({64'd0, cand} * {64'd0, cand} <= disc_u) root = cand;
      end
      sq = $signed({64'd0, root});
      nb = -qb;
      o.near_root = quot32((nb - sq) <<< FRAC, qa <<< 1);
      o.far_root = quot32((nb + sq) <<< FRAC, qa <<< 1);
      o.hit_status = ST_HIT;
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) hit_q.push_back(solve_ray(req_data));
         if (!(req_valid && req_stall)) begin
            if (ray_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_data <= ray_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            failed = 1;
         end else begin
            want = hit_q.pop_front();
            if (rsp_data.near_root !== want.near_root) begin
               $display("%0t: near_root expected %h got %h", $time,
                        want.near_root, rsp_data.near_root);
               failed = 1;
            end
            if (rsp_data.far_root !== want.far_root) begin
               $display("%0t: far_root expected %h got %h", $time,
                        want.far_root, rsp_data.far_root);
               failed = 1;
            end
            if (rsp_data.hit_status !== want.hit_status) begin
               $display("%0t: hit_status expected %0d got %0d", $time,
                        want.hit_status, rsp_data.hit_status);
               failed = 1;
            end
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_CONE_TAN_SQ) tan_sq_reg = val;
      else if (idx == CSR_OPEN_OFFSET) open_reg = val;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // sampled mid-cycle so the driver's updates at the edge are settled
   task automatic drain();
      while (ray_q.size() > 0 || req_valid || hit_q.size() > 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($signed($urandom_range(32'h20_0000)) - 32'sh10_0000);
         3: return 32'($signed($urandom_range(32'h400_0000)) - 32'sh200_0000);
         default: return 32'($signed($urandom_range(32'h2_0000)) - 32'sh1_0000) <<< 4;
      endcase
   endfunction

   function automatic req_type rand_ray();
      req_type r;
      r.eye_x = rand_coord(); r.eye_y = rand_coord(); r.eye_z = rand_coord();
      r.dir_x = rand_coord(); r.dir_y = rand_coord(); r.dir_z = rand_coord();
      // occasional degenerate or axis-aligned direction
      case ($urandom_range(9))
         0: begin r.dir_x = '0; r.dir_y = '0; r.dir_z = '0; end
         1: begin r.dir_z = '0; end
         2: begin r.dir_x = '0; r.dir_y = '0; end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type mk_ray(input int ex, ey, ez, dx, dy, dz);
      req_type r;
      r.eye_x = ex; r.eye_y = ey; r.eye_z = ez;
      r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
      return r;
   endfunction

   initial begin
      logic [31:0] tan_set[8];
      logic [31:0] open_set[8];
      int idle_set[8];
      int stall_set[8];
      tan_sq_reg = 32'h0001_0000;
      open_reg = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: unit hyperboloid with an opening of -1
      write_reg(CSR_OPEN_OFFSET, 32'hFFFF_0000);
      ray_q.push_back(mk_ray(0, 0, 0, 0, 0, 0));
      ray_q.push_back(mk_ray(-5 << 16, 0, 0, 1 << 16, 0, 0));
      ray_q.push_back(mk_ray(0, -3 << 16, 1 << 16, 0, 1 << 16, 0));
      ray_q.push_back(mk_ray(0, 0, -4 << 16, 0, 0, 1 << 16));
      ray_q.push_back(mk_ray(2 << 16, 0, 0, 1 << 16, 0, 1 << 16));
      ray_q.push_back(mk_ray(0, 0, 0, 1, 1, 1));
      ray_q.push_back(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      ray_q.push_back(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      ray_q.push_back(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 1, -1));
      ray_q.push_back(mk_ray(-1, -1, -1, -1, -1, -1));
      ray_q.push_back(mk_ray(1 << 16, 0, 0, 0, 0, 1 << 16));
      ray_q.push_back(mk_ray(0, 0, 0, 1 << 16, 0, 1 << 16));
      drain();
      // positive opening: the ray along x misses, the other two hit
      write_reg(CSR_OPEN_OFFSET, 32'h0001_0000);
      ray_q.push_back(mk_ray(0, 0, 0, 1 << 16, 0, 0));
      ray_q.push_back(mk_ray(0, 0, 5 << 16, 1 << 16, 1 << 16, 0));
      ray_q.push_back(mk_ray(-3 << 16, 0, 0, 0, 0, 1 << 16));
      drain();

      tan_set = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000,
                  32'h0004_0000, 32'h0000_0001, 32'h8000_0000, 32'h0001_0000};
      open_set = '{32'h0000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFC_0000};
      idle_set = '{0, 62, 0, 7, 62, 0, 7, 0};
      stall_set = '{0, 0, 62, 7, 0, 62, 7, 0};
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_CONE_TAN_SQ, (ph == 3) ? $urandom() : tan_set[ph]);
         write_reg(CSR_OPEN_OFFSET, (ph == 4) ? $urandom() : open_set[ph]);
         idle_pct = idle_set[ph];
         stall_pct = stall_set[ph];
         for (int k = 0; k < 175; k++) ray_q.push_back(rand_ray());
         drain();
      end
      stall_pct = 0;
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (!failed && hit_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

/* filelist.f */
hw/rtl/rhi_pkg.sv
hw/rtl/rhi_coef.sv
hw/rtl/rhi_disc.sv
hw/rtl/rhi_isqrt.sv
hw/rtl/rhi_div.sv
hw/rtl/ray_hyperboloid_intersect_top.sv
test/testbench.sv
